FILE: hw/rtl/trsd_pkg.sv
`default_nettype none

package trsd_pkg;

   // Parser phase codes
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_TIME   = 3'd1;
   localparam logic [2:0] PH_LENGTH = 3'd2;
   localparam logic [2:0] PH_KEY    = 3'd3;
   localparam logic [2:0] PH_VHIGH  = 3'd4;
   localparam logic [2:0] PH_VLOW   = 3'd5;
   localparam logic [2:0] PH_SKIP   = 3'd6;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_POINT  = 2'd1;
   localparam logic [1:0] KIND_TRUNC  = 2'd2;

   // Byte counts of the fixed fields
   localparam logic [2:0] HDR_LEN      = 3'd5;
   localparam logic [2:0] WORD_BYTES   = 3'd2;
   localparam logic [15:0] TRIPLE_BYTES = 16'd3;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  format_version;
      logic [5:0]  stamp_year;
      logic [3:0]  stamp_month;
      logic [4:0]  stamp_day;
      logic [4:0]  stamp_hour;
      logic [5:0]  stamp_minute;
      logic [5:0]  stamp_second;
      logic [15:0] point_time;
      logic [7:0]  point_key;
      logic [15:0] point_value;
   } result_type;

   // Pick the phase that follows a finished length or triple
   function automatic logic [2:0] body_phase(input logic [15:0] left);
      logic [2:0] ph;
      if (left == 16'd0) begin
         ph = PH_TIME;
      end else if (left < TRIPLE_BYTES) begin
         ph = PH_SKIP;
      end else begin
         ph = PH_KEY;
      end
      return ph;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/timed_record_stream_decoder.sv
`default_nettype none

// Decodes a record stream one byte per cycle while req_stall is low. A five-byte
// header (version and a packed timestamp) yields one header item; each following
// record is a 16-bit time offset, a 16-bit length and key/value triples, and each
// complete triple yields one point item. A byte flagged end_of_file inside a
// header or a record yields a truncation item (unless it completes a header, a
// point or the record) and returns the parser to the header phase. Each result
// is registered in the result register that drives the rsp_ side, or in the skid
// register while a result waits there; this two-entry output buffer lets bytes
// keep flowing while one result waits, and req_stall rises only when both are full.
module timed_record_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_end_of_file,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_format_version,
   output logic [5:0]       rsp_stamp_year,
   output logic [3:0]       rsp_stamp_month,
   output logic [4:0]       rsp_stamp_day,
   output logic [4:0]       rsp_stamp_hour,
   output logic [5:0]       rsp_stamp_minute,
   output logic [5:0]       rsp_stamp_second,
   output logic [15:0]      rsp_point_time,
   output logic [7:0]       rsp_point_key,
   output logic [15:0]      rsp_point_value
);
   import trsd_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] shift_ff, shift_in;
   logic [7:0]  version_ff, version_in;
   logic [15:0] time_ff, time_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  key_ff, key_in;
   logic [7:0]  vhigh_ff, vhigh_in;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_ff, skid_in;

   logic        accept;
   logic        out_take;
   logic [2:0]  count_inc;
   logic        res_ok;
   result_type  res;

   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign count_inc = count_ff + 3'd1;

   // Parse one byte: next state and optional result
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      version_in = version_ff;
      time_in    = time_ff;
      left_in    = left_ff;
      key_in     = key_ff;
      vhigh_in   = vhigh_ff;
      res        = '0;
      res_ok     = 1'b0;

      unique case (phase_ff)
         PH_TIME: begin
            time_in  = {time_ff[7:0], req_stream_byte};
            count_in = count_inc;
            if (count_inc >= WORD_BYTES) begin
               count_in = 3'd0;
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            left_in  = {left_ff[7:0], req_stream_byte};
            count_in = count_inc;
            if (count_inc >= WORD_BYTES) begin
               count_in = 3'd0;
               phase_in = body_phase(left_in);
            end
         end
         PH_KEY: begin
            key_in   = req_stream_byte;
            left_in  = left_ff - 16'd1;
            phase_in = PH_VHIGH;
         end
         PH_VHIGH: begin
            vhigh_in = req_stream_byte;
            left_in  = left_ff - 16'd1;
            phase_in = PH_VLOW;
         end
         PH_VLOW: begin
            left_in         = left_ff - 16'd1;
            res.result_kind = KIND_POINT;
            res.point_time  = time_ff;
            res.point_key   = key_ff;
            res.point_value = {vhigh_ff, req_stream_byte};
            res_ok          = 1'b1;
            phase_in        = body_phase(left_in);
            count_in        = 3'd0;
         end
         PH_SKIP: begin
            left_in = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               phase_in = PH_TIME;
               count_in = 3'd0;
            end
         end
         default: begin
            // header phase, also any unused code
            if (count_ff == 3'd0) begin
               version_in = req_stream_byte;
               shift_in   = '0;
            end else begin
               shift_in = {shift_ff[23:0], req_stream_byte};
            end
            count_in = count_inc;
            if (count_inc >= HDR_LEN) begin
               res.result_kind    = KIND_HEADER;
               res.format_version = version_ff;
               res.stamp_year     = shift_in[31:26];
               res.stamp_month    = shift_in[25:22];
               res.stamp_day      = shift_in[21:17];
               res.stamp_hour     = shift_in[16:12];
               res.stamp_minute   = shift_in[11:6];
               res.stamp_second   = shift_in[5:0];
               res_ok             = 1'b1;
               phase_in           = PH_TIME;
               count_in           = 3'd0;
               time_in            = '0;
               left_in            = '0;
            end
         end
      endcase

      // End of file: flag a cut record, then clear everything
      if (req_end_of_file) begin
         if (!(phase_in == PH_TIME && count_in == 3'd0) && !res_ok) begin
            res             = '0;
            res.result_kind = KIND_TRUNC;
            res_ok          = 1'b1;
         end
         phase_in   = PH_HEADER;
         count_in   = '0;
         shift_in   = '0;
         version_in = '0;
         time_in    = '0;
         left_in    = '0;
         key_in     = '0;
         vhigh_in   = '0;
      end
   end

   // Steer results into the result register or the skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && res_ok) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Advance parser state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         count_ff   <= '0;
         shift_ff   <= '0;
         version_ff <= '0;
         time_ff    <= '0;
         left_ff    <= '0;
         key_ff     <= '0;
         vhigh_ff   <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
         version_ff <= version_in;
         time_ff    <= time_in;
         left_ff    <= left_in;
         key_ff     <= key_in;
         vhigh_ff   <= vhigh_in;
      end
   end

   // Hold output buffer flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold output buffer payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall          = skid_valid_ff;
   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_ff.result_kind;
   assign rsp_format_version = out_ff.format_version;
   assign rsp_stamp_year     = out_ff.stamp_year;
   assign rsp_stamp_month    = out_ff.stamp_month;
   assign rsp_stamp_day      = out_ff.stamp_day;
   assign rsp_stamp_hour     = out_ff.stamp_hour;
   assign rsp_stamp_minute   = out_ff.stamp_minute;
   assign rsp_stamp_second   = out_ff.stamp_second;
   assign rsp_point_time     = out_ff.point_time;
   assign rsp_point_key      = out_ff.point_key;
   assign rsp_point_value    = out_ff.point_value;

   // Skid entry only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   // A key byte is only expected when a full triple remains
   a_key_has_triple: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_KEY) |-> (left_ff >= TRIPLE_BYTES))
      else $error("key phase entered with fewer than three bytes left");

   // Skip phase covers one or two trailing bytes
   a_skip_short: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (left_ff != 16'd0 && left_ff < TRIPLE_BYTES))
      else $error("skip phase with an out-of-range byte count");

   // End of file returns the parser to the header start
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_file) |=> (phase_ff == PH_HEADER && count_ff == 3'd0))
      else $error("parser not back at header start after end of file");

endmodule

`default_nettype wire
